>>> rtl/core/bonding_key_cache_lru_top_assert.svh
// Assertion macros for the bonding key cache.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BONDING_KEY_CACHE_LRU_TOP_ASSERT_SVH
`define BONDING_KEY_CACHE_LRU_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Plain property, checked at every clock edge outside reset.
`define BKC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bkc assertion failed");
// Overlapping implication, checked at every clock edge outside reset.
`define BKC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bkc assertion failed");
`else
`define BKC_ASSERT(name, clk, rst_n, prop)
`define BKC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/bkc_pkg.sv
// Shared types and constants for the bonding key cache.
// Used by bkc_cell and bonding_key_cache_lru_top; depends on nothing.
package bkc_pkg;

  localparam int ADDR_W      = 48;
  localparam int KIND_W      = 8;
  localparam int KEY_W       = 64;
  localparam int TIME_W      = 32;
  localparam int OUTCOME_W   = 2;
  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int DEF_ENTRIES = 16;

  // One table entry as it is held in a cell.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  long_high;
    logic [KEY_W-1:0]  long_low;
    logic [KEY_W-1:0]  ident_high;
    logic [KEY_W-1:0]  ident_low;
    logic [TIME_W-1:0] last_use;
  } entry_t;

  // Write controls for one cell.
  typedef struct packed {
    logic refresh;      // update the entry in place
    logic load_new;     // take the new entry
    logic shift_in;     // take the neighbor's entry
    logic ident_given;  // the new identity key is valid
  } cell_ctl_t;

  // Oldest-entry search wave that moves one cell per cycle.
  typedef struct packed {
    logic              vld;
    logic              has;
    logic [TIME_W-1:0] last_use;
    logic [ADDR_W-1:0] addr;
  } scan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_WRITE
  } state_e;

  typedef enum logic [1:0] {
    MODE_UPDATE,
    MODE_APPEND,
    MODE_EVICT
  } mode_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_UPDATED  = 2'd0,
    OUTCOME_APPENDED = 2'd1,
    OUTCOME_EVICTED  = 2'd2
  } outcome_e;

endpackage

>>> rtl/core/bkc_cell.sv
// One cell of the key cache chain: holds a single entry, matches the lookup
// address and forwards the oldest-entry search wave. Depends on bkc_pkg.
module bkc_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [bkc_pkg::ADDR_W-1:0]     key_i,
  input  bkc_pkg::cell_ctl_t             ctl_i,
  input  bkc_pkg::entry_t                new_i,
  input  bkc_pkg::entry_t                next_i,
  output bkc_pkg::entry_t                entry_o,
  output logic                           hit_o,
  input  bkc_pkg::scan_t                 scan_i,
  input  logic [IDX_W-1:0]               scan_idx_i,
  output bkc_pkg::scan_t                 scan_o,
  output logic [IDX_W-1:0]               scan_idx_o
);

  bkc_pkg::entry_t   entry_q, entry_d;
  logic              scan_vld_q;
  logic              scan_has_q;
  logic [bkc_pkg::TIME_W-1:0] scan_time_q;
  logic [bkc_pkg::ADDR_W-1:0] scan_addr_q;
  logic [IDX_W-1:0]  scan_idx_q;
  logic              take_own;

  // Address match, only for entries inside the used range.
  assign hit_o   = valid_i && (entry_q.addr == key_i);
  assign entry_o = entry_q;

  // Entry write: shift from the neighbor, load new, or refresh in place.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift_in) begin
      entry_d = next_i;
    end else if (ctl_i.load_new) begin
      entry_d = new_i;
    end else if (ctl_i.refresh) begin
      entry_d      = new_i;
      entry_d.addr = entry_q.addr;
      if (!ctl_i.ident_given) begin
        entry_d.ident_high = entry_q.ident_high;
        entry_d.ident_low  = entry_q.ident_low;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // The wave keeps the first strictly smaller time, so ties go to the lower index.
  assign take_own = !scan_i.has || (entry_q.last_use < scan_i.last_use);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_vld_q <= 1'b0;
    end else begin
      scan_vld_q <= scan_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_has_q <= 1'b1;
    if (take_own) begin
      scan_time_q <= entry_q.last_use;
      scan_addr_q <= entry_q.addr;
      scan_idx_q  <= IDX_W'(CELL_IDX);
    end else begin
      scan_time_q <= scan_i.last_use;
      scan_addr_q <= scan_i.addr;
      scan_idx_q  <= scan_idx_i;
    end
  end

  assign scan_o.vld      = scan_vld_q;
  assign scan_o.has      = scan_has_q;
  assign scan_o.last_use = scan_time_q;
  assign scan_o.addr     = scan_addr_q;
  assign scan_idx_o      = scan_idx_q;

endmodule

>>> rtl/core/bonding_key_cache_lru_top.sv
// Bonding key cache with least-recently-used eviction, built as a row of
// CACHE_ENTRIES cells. An added device whose address is present refreshes its
// entry; otherwise it is appended, and when the table is full the entry with
// the smallest last-use time (lowest index on ties) leaves first while the
// later cells shift down by one. One beat in gives one beat out. An update or
// a plain append passes the lookup and the write states; an add that evicts
// also waits in the search state while the oldest-entry search travels the
// cell row one cell per cycle. A new beat is taken only when the previous add
// has been written into the cells; the result register lets the next beat in
// while a finished result still waits.
// Depends on bkc_pkg, bkc_cell and bonding_key_cache_lru_top_assert.svh.
`include "bonding_key_cache_lru_top_assert.svh"

module bonding_key_cache_lru_top #(
  parameter int CACHE_ENTRIES = bkc_pkg::DEF_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bkc_pkg::ADDR_W-1:0]      device_address_i,
  input  logic [bkc_pkg::KIND_W-1:0]      address_kind_i,
  input  logic [bkc_pkg::KEY_W-1:0]       long_key_high_i,
  input  logic [bkc_pkg::KEY_W-1:0]       long_key_low_i,
  input  logic [bkc_pkg::KEY_W-1:0]       identity_key_high_i,
  input  logic [bkc_pkg::KEY_W-1:0]       identity_key_low_i,
  input  logic                            identity_key_given_i,
  input  logic [bkc_pkg::TIME_W-1:0]      now_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bkc_pkg::OUTCOME_W-1:0]   outcome_o,
  output logic [bkc_pkg::SLOT_W-1:0]      slot_o,
  output logic [bkc_pkg::ADDR_W-1:0]      evicted_address_o,
  output logic [bkc_pkg::COUNT_W-1:0]     entry_count_o
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  bkc_pkg::state_e   state_q, state_d;
  bkc_pkg::mode_e    mode_q, mode_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  bkc_pkg::entry_t   item_q;
  logic              given_q;
  logic [CACHE_ENTRIES-1:0] hit_q;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]  pick_q;
  logic [bkc_pkg::ADDR_W-1:0] evict_q;

  logic              out_valid_q;
  bkc_pkg::outcome_e outcome_q, outcome_d;
  logic [bkc_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic [bkc_pkg::ADDR_W-1:0]  evaddr_q, evaddr_d;
  logic [bkc_pkg::COUNT_W-1:0] count_q;

  logic              in_accept;
  logic              out_free;
  logic              scan_start;
  logic              write_go;
  logic              scan_done;

  bkc_pkg::entry_t    new_entry;
  bkc_pkg::entry_t    entry_w [CACHE_ENTRIES];
  bkc_pkg::cell_ctl_t ctl_w   [CACHE_ENTRIES];
  bkc_pkg::scan_t     scan_w  [CACHE_ENTRIES];
  logic [IDX_W-1:0]   sidx_w  [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] hit_w;
  bkc_pkg::scan_t     scan_head;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign scan_done = scan_w[CACHE_ENTRIES-1].vld;

  // New entry as it is stored on append; the identity key is zero unless given.
  always_comb begin
    new_entry = item_q;
    if (!given_q) begin
      new_entry.ident_high = '0;
      new_entry.ident_low  = '0;
    end
  end

  // Head of the search wave: no candidate yet.
  always_comb begin
    scan_head          = '0;
    scan_head.vld      = scan_start;
    scan_head.has      = 1'b0;
  end

  // Per-cell write controls for the add that is being committed.
  always_comb begin
    for (int k = 0; k < CACHE_ENTRIES; k++) begin
      ctl_w[k]             = '0;
      ctl_w[k].ident_given = given_q;
      if (write_go) begin
        unique case (mode_q)
          bkc_pkg::MODE_UPDATE: ctl_w[k].refresh  = hit_q[k];
          bkc_pkg::MODE_APPEND: ctl_w[k].load_new = (CNT_W'(k) == cnt_q);
          bkc_pkg::MODE_EVICT: begin
            if (k == CACHE_ENTRIES - 1) begin
              ctl_w[k].load_new = 1'b1;
            end else begin
              ctl_w[k].shift_in = (IDX_W'(k) >= pick_q);
            end
          end
          default: ctl_w[k] = '0;
        endcase
      end
    end
  end

  // The cell row.
  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    bkc_pkg::entry_t next_w;
    bkc_pkg::scan_t  sin_w;
    logic [IDX_W-1:0] sin_idx_w;

    if (g == CACHE_ENTRIES - 1) begin : g_tail
      assign next_w = new_entry;
    end else begin : g_body
      assign next_w = entry_w[g+1];
    end

    if (g == 0) begin : g_head
      assign sin_w     = scan_head;
      assign sin_idx_w = '0;
    end else begin : g_link
      assign sin_w     = scan_w[g-1];
      assign sin_idx_w = sidx_w[g-1];
    end

    bkc_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .valid_i    (CNT_W'(g) < cnt_q),
      .key_i      (item_q.addr),
      .ctl_i      (ctl_w[g]),
      .new_i      (new_entry),
      .next_i     (next_w),
      .entry_o    (entry_w[g]),
      .hit_o      (hit_w[g]),
      .scan_i     (sin_w),
      .scan_idx_i (sin_idx_w),
      .scan_o     (scan_w[g]),
      .scan_idx_o (sidx_w[g])
    );
  end

  // Index of the matching cell; at most one cell matches.
  always_comb begin
    hit_idx_d = '0;
    for (int k = 0; k < CACHE_ENTRIES; k++) begin
      hit_idx_d = hit_idx_d | (hit_w[k] ? IDX_W'(k) : '0);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bkc_pkg::ST_IDLE:  if (in_accept) state_d = bkc_pkg::ST_LOOK;
      bkc_pkg::ST_LOOK: begin
        if ((|hit_w) || (cnt_q < CNT_W'(CACHE_ENTRIES))) begin
          state_d = bkc_pkg::ST_WRITE;
        end else begin
          state_d = bkc_pkg::ST_SCAN;
        end
      end
      bkc_pkg::ST_SCAN:  if (scan_done) state_d = bkc_pkg::ST_WRITE;
      bkc_pkg::ST_WRITE: if (out_free) state_d = bkc_pkg::ST_IDLE;
      default:           state_d = bkc_pkg::ST_IDLE;
    endcase
  end

  // State-driven outputs.
  always_comb begin
    in_stall_o = 1'b1;
    scan_start = 1'b0;
    write_go   = 1'b0;
    unique case (state_q)
      bkc_pkg::ST_IDLE:  in_stall_o = 1'b0;
      bkc_pkg::ST_LOOK:  scan_start = !(|hit_w) && (cnt_q >= CNT_W'(CACHE_ENTRIES));
      bkc_pkg::ST_SCAN:  ;
      bkc_pkg::ST_WRITE: write_go = out_free;
      default:           in_stall_o = 1'b1;
    endcase
  end

  // Mode decision at the end of the lookup.
  always_comb begin
    mode_d = mode_q;
    if (state_q == bkc_pkg::ST_LOOK) begin
      if (|hit_w) begin
        mode_d = bkc_pkg::MODE_UPDATE;
      end else if (cnt_q < CNT_W'(CACHE_ENTRIES)) begin
        mode_d = bkc_pkg::MODE_APPEND;
      end else begin
        mode_d = bkc_pkg::MODE_EVICT;
      end
    end
  end

  // Result of the committed add.
  always_comb begin
    cnt_d     = cnt_q;
    outcome_d = bkc_pkg::OUTCOME_UPDATED;
    slot_d    = bkc_pkg::SLOT_W'(hit_idx_q);
    evaddr_d  = '0;
    unique case (mode_q)
      bkc_pkg::MODE_UPDATE: ;
      bkc_pkg::MODE_APPEND: begin
        cnt_d     = cnt_q + CNT_W'(1);
        outcome_d = bkc_pkg::OUTCOME_APPENDED;
        slot_d    = bkc_pkg::SLOT_W'(cnt_q);
      end
      bkc_pkg::MODE_EVICT: begin
        outcome_d = bkc_pkg::OUTCOME_EVICTED;
        slot_d    = bkc_pkg::SLOT_W'(CACHE_ENTRIES - 1);
        evaddr_d  = evict_q;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bkc_pkg::ST_IDLE;
      mode_q      <= bkc_pkg::MODE_UPDATE;
      cnt_q       <= '0;
      hit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      if (state_q == bkc_pkg::ST_LOOK) begin
        hit_q <= hit_w;
      end
      if (write_go) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.addr       <= device_address_i;
      item_q.kind       <= address_kind_i;
      item_q.long_high  <= long_key_high_i;
      item_q.long_low   <= long_key_low_i;
      item_q.ident_high <= identity_key_high_i;
      item_q.ident_low  <= identity_key_low_i;
      item_q.last_use   <= now_ms_i;
      given_q           <= identity_key_given_i;
    end
    if (state_q == bkc_pkg::ST_LOOK) begin
      hit_idx_q <= hit_idx_d;
    end
    if (scan_done) begin
      pick_q  <= sidx_w[CACHE_ENTRIES-1];
      evict_q <= scan_w[CACHE_ENTRIES-1].addr;
    end
    if (write_go) begin
      outcome_q <= outcome_d;
      slot_q    <= slot_d;
      evaddr_q  <= evaddr_d;
      count_q   <= bkc_pkg::COUNT_W'(cnt_d);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign outcome_o         = outcome_q;
  assign slot_o            = slot_q;
  assign evicted_address_o = evaddr_q;
  assign entry_count_o     = count_q;

  // Addresses in the table are unique, so no more than one cell matches.
  `BKC_ASSERT(a_hit_unique, clk_i, rst_ni, $onehot0(hit_w))
  // The fill count never goes past the number of cells.
  `BKC_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(CACHE_ENTRIES))
  // The search wave reaches the tail only while the sequencer waits for it.
  `BKC_ASSERT_IMP(a_scan_state, clk_i, rst_ni, scan_done, state_q == bkc_pkg::ST_SCAN)
  // An eviction search runs only on a full table.
  `BKC_ASSERT_IMP(a_scan_full, clk_i, rst_ni, state_q == bkc_pkg::ST_SCAN,
                  cnt_q == CNT_W'(CACHE_ENTRIES))
  // A fresh result follows a commit in the previous cycle.
  `BKC_ASSERT_IMP(a_out_after_write, clk_i, rst_ni, $rose(out_valid_q),
                  $past(state_q == bkc_pkg::ST_WRITE))

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bonding key cache: directed pairing adds,
// then random adds, predicted by a behavioral table model and compared beat by beat.
// Depends on bkc_pkg and bonding_key_cache_lru_top.
module tb_top;

  localparam int CACHE_ENTRIES = bkc_pkg::DEF_ENTRIES;
  localparam int ITEM_TOTAL    = 1050;
  localparam int CALM_TAIL     = 150;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 2 * CACHE_ENTRIES + 8;
  localparam int LIMIT_NS      = 3_000_000;

  // One pairing add as offered on the input channel.
  typedef struct {
    logic [bkc_pkg::ADDR_W-1:0] addr;
    logic [bkc_pkg::KIND_W-1:0] kind;
    logic [bkc_pkg::KEY_W-1:0]  long_hi;
    logic [bkc_pkg::KEY_W-1:0]  long_lo;
    logic [bkc_pkg::KEY_W-1:0]  ident_hi;
    logic [bkc_pkg::KEY_W-1:0]  ident_lo;
    logic                       ident_given;
    logic [bkc_pkg::TIME_W-1:0] now;
  } pair_req_t;

  // One result beat.
  typedef struct {
    bkc_pkg::outcome_e           outcome;
    logic [bkc_pkg::SLOT_W-1:0]  slot;
    logic [bkc_pkg::ADDR_W-1:0]  evicted;
    logic [bkc_pkg::COUNT_W-1:0] count;
  } pair_res_t;

  // One bonded device as the table model holds it.
  typedef struct {
    logic [bkc_pkg::ADDR_W-1:0] addr;
    logic [bkc_pkg::KIND_W-1:0] kind;
    logic [bkc_pkg::KEY_W-1:0]  long_hi;
    logic [bkc_pkg::KEY_W-1:0]  long_lo;
    logic [bkc_pkg::KEY_W-1:0]  ident_hi;
    logic [bkc_pkg::KEY_W-1:0]  ident_lo;
    logic [bkc_pkg::TIME_W-1:0] last_use;
  } bond_rec_t;

  // A row of the directed table; fixed rows carry a typed-in result.
  typedef struct {
    pair_req_t req;
    bit        fixed;
    pair_res_t res;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [bkc_pkg::ADDR_W-1:0]    device_address_i;
  logic [bkc_pkg::KIND_W-1:0]    address_kind_i;
  logic [bkc_pkg::KEY_W-1:0]     long_key_high_i;
  logic [bkc_pkg::KEY_W-1:0]     long_key_low_i;
  logic [bkc_pkg::KEY_W-1:0]     identity_key_high_i;
  logic [bkc_pkg::KEY_W-1:0]     identity_key_low_i;
  logic                          identity_key_given_i;
  logic [bkc_pkg::TIME_W-1:0]    now_ms_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [bkc_pkg::OUTCOME_W-1:0] outcome_o;
  logic [bkc_pkg::SLOT_W-1:0]    slot_o;
  logic [bkc_pkg::ADDR_W-1:0]    evicted_address_o;
  logic [bkc_pkg::COUNT_W-1:0]   entry_count_o;

  bond_rec_t                  bond_tab [CACHE_ENTRIES];
  int                         bond_used;
  logic [bkc_pkg::ADDR_W-1:0] evicted_addrs [$];
  logic [bkc_pkg::TIME_W-1:0] clock_ms;
  dir_row_t                   dir_table [$];
  pair_res_t                  pending_results [$];
  int                         items_in;
  int                         results_out;
  int                         fault_count;
  logic                       hold_off;

  bonding_key_cache_lru_top #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .device_address_i    (device_address_i),
    .address_kind_i      (address_kind_i),
    .long_key_high_i     (long_key_high_i),
    .long_key_low_i      (long_key_low_i),
    .identity_key_high_i (identity_key_high_i),
    .identity_key_low_i  (identity_key_low_i),
    .identity_key_given_i(identity_key_given_i),
    .now_ms_i            (now_ms_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .outcome_o           (outcome_o),
    .slot_o              (slot_o),
    .evicted_address_o   (evicted_address_o),
    .entry_count_o       (entry_count_o)
  );

  // Clock and a single reset at the start of the run.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Run limit.
  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Table model of the cache: applies one add and returns the result it causes.
  function automatic pair_res_t predict_pairing(pair_req_t r);
    pair_res_t res;
    int        hit;
    int        oldest;
    hit = -1;
    for (int k = 0; k < bond_used; k++) begin
      if (hit < 0 && bond_tab[k].addr == r.addr) hit = k;
    end
    res.evicted = '0;

    // Known address: refresh in place, keeping the identity key unless a new one came.
    if (hit >= 0) begin
      bond_tab[hit].kind     = r.kind;
      bond_tab[hit].long_hi  = r.long_hi;
      bond_tab[hit].long_lo  = r.long_lo;
      bond_tab[hit].last_use = r.now;
      if (r.ident_given) begin
        bond_tab[hit].ident_hi = r.ident_hi;
        bond_tab[hit].ident_lo = r.ident_lo;
      end
      res.outcome = bkc_pkg::OUTCOME_UPDATED;
      res.slot    = bkc_pkg::SLOT_W'(hit);
      res.count   = bkc_pkg::COUNT_W'(bond_used);
      return res;
    end

    // Full table: drop the oldest entry, lowest index on ties, and close the gap.
    res.outcome = bkc_pkg::OUTCOME_APPENDED;
    if (bond_used >= CACHE_ENTRIES) begin
      oldest = 0;
      for (int k = 1; k < bond_used; k++) begin
        if (bond_tab[k].last_use < bond_tab[oldest].last_use) oldest = k;
      end
      res.evicted = bond_tab[oldest].addr;
      res.outcome = bkc_pkg::OUTCOME_EVICTED;
      evicted_addrs.push_back(bond_tab[oldest].addr);
      if (evicted_addrs.size() > 32) void'(evicted_addrs.pop_front());
      for (int k = oldest; k + 1 < bond_used; k++) bond_tab[k] = bond_tab[k + 1];
      bond_tab[bond_used - 1] = '{default: '0};
      bond_used--;
    end

    // Append; a missing identity key is stored as zero.
    bond_tab[bond_used].addr     = r.addr;
    bond_tab[bond_used].kind     = r.kind;
    bond_tab[bond_used].long_hi  = r.long_hi;
    bond_tab[bond_used].long_lo  = r.long_lo;
    bond_tab[bond_used].ident_hi = r.ident_given ? r.ident_hi : '0;
    bond_tab[bond_used].ident_lo = r.ident_given ? r.ident_lo : '0;
    bond_tab[bond_used].last_use = r.now;
    res.slot = bkc_pkg::SLOT_W'(bond_used);
    bond_used++;
    res.count = bkc_pkg::COUNT_W'(bond_used);
    return res;
  endfunction

  // Adds one directed row; the key pattern is spread over all four key halves.
  function automatic void table_row(logic [bkc_pkg::ADDR_W-1:0] a,
                                    logic [bkc_pkg::KIND_W-1:0] kd,
                                    logic [bkc_pkg::KEY_W-1:0] key, logic g,
                                    logic [bkc_pkg::TIME_W-1:0] t,
                                    bit fx, bkc_pkg::outcome_e o,
                                    logic [bkc_pkg::SLOT_W-1:0] s,
                                    logic [bkc_pkg::COUNT_W-1:0] c);
    dir_row_t row;
    row.req = '{addr: a, kind: kd, long_hi: key, long_lo: ~key,
                ident_hi: {key[31:0], key[63:32]}, ident_lo: key ^ 64'h5A5A_A5A5_3C3C_C3C3,
                ident_given: g, now: t};
    row.fixed = fx;
    row.res   = '{outcome: o, slot: s, evicted: '0, count: c};
    dir_table.push_back(row);
  endfunction

  // Directed part: extremes, in-place updates with and without identity key,
  // filling to capacity, eviction with tied times, no-wrap time compare.
  function automatic void build_table();
    table_row(48'h0, 8'h00, 64'h0, 1'b0, 32'd100,
              1, bkc_pkg::OUTCOME_APPENDED, 4'd0, 5'd1);
    table_row('1, 8'hFF, '1, 1'b1, 32'hFFFF_FFFF,
              1, bkc_pkg::OUTCOME_APPENDED, 4'd1, 5'd2);
    table_row(48'h0, 8'h5A, 64'h0123_4567_89AB_CDEF, 1'b0, 32'd5,
              1, bkc_pkg::OUTCOME_UPDATED, 4'd0, 5'd2);
    table_row('1, 8'hA5, 64'hFEDC_BA98_7654_3210, 1'b1, 32'hFFFF_FFFF,
              1, bkc_pkg::OUTCOME_UPDATED, 4'd1, 5'd2);
    // Same time as the entry in slot 0, so the first eviction sees a tie.
    table_row(48'h1000, 8'h01, 64'h1111, 1'b1, 32'd5,
              0, bkc_pkg::OUTCOME_UPDATED, '0, '0);
    for (int i = 1; i <= 12; i++) begin
      table_row(48'h1000 + i, 8'(i), 64'h2222 * i, 1'(i % 2), 32'd1000 + i,
                0, bkc_pkg::OUTCOME_UPDATED, '0, '0);
    end
    table_row(48'h100D, 8'h0D, 64'hDDDD, 1'b0, 32'd1013,
              1, bkc_pkg::OUTCOME_APPENDED, 4'd15, 5'd16);
    table_row(48'h8000_0000_0001, 8'h80, 64'h8001, 1'b1, 32'd2000,
              0, bkc_pkg::OUTCOME_UPDATED, '0, '0);
    table_row(48'h8000_0000_0002, 8'h81, 64'h8002, 1'b0, 32'd2001,
              0, bkc_pkg::OUTCOME_UPDATED, '0, '0);
    table_row(48'h7FFF_FFFF_FFFF, 8'h7F, 64'h7777, 1'b1, 32'd0,
              0, bkc_pkg::OUTCOME_UPDATED, '0, '0);
    // The entry just added is the oldest and sits in the last slot.
    table_row(48'h3, 8'h03, 64'h3333, 1'b0, 32'd0,
              0, bkc_pkg::OUTCOME_UPDATED, '0, '0);
    table_row('1, 8'hEE, 64'hEEEE, 1'b0, 32'd3000,
              0, bkc_pkg::OUTCOME_UPDATED, '0, '0);
    table_row(48'h3, 8'h33, 64'h3434, 1'b1, 32'd1,
              0, bkc_pkg::OUTCOME_UPDATED, '0, '0);
    table_row(48'h0, 8'h00, 64'h0, 1'b0, 32'd3001,
              0, bkc_pkg::OUTCOME_UPDATED, '0, '0);
  endfunction

  // Random add: mostly known or recently evicted addresses so that updates,
  // re-adds and evictions all keep happening; times mostly creep up with ties.
  function automatic pair_req_t random_request();
    pair_req_t   r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45 && bond_used > 0)
      r.addr = bond_tab[$urandom_range(0, bond_used - 1)].addr;
    else if (pick < 55 && evicted_addrs.size() > 0)
      r.addr = evicted_addrs[$urandom_range(0, evicted_addrs.size() - 1)];
    else if (pick < 58)
      r.addr = '0;
    else if (pick < 61)
      r.addr = '1;
    else
      r.addr = {16'($urandom), 32'($urandom)};
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 2);
    r.kind        = 8'($urandom);
    r.long_hi     = {$urandom, $urandom};
    r.long_lo     = {$urandom, $urandom};
    r.ident_hi    = {$urandom, $urandom};
    r.ident_lo    = {$urandom, $urandom};
    r.ident_given = 1'($urandom_range(0, 1));
    r.now         = clock_ms;
    return r;
  endfunction

  // Compares one accepted result beat with the oldest pending expectation.
  task automatic check_result();
    pair_res_t want;
    results_out++;
    if (pending_results.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t: result beat with none pending: outcome %0d slot %0d count %0d",
                 $realtime, outcome_o, slot_o, entry_count_o);
      return;
    end
    want = pending_results.pop_front();
    if (outcome_o !== want.outcome || slot_o !== want.slot ||
        evicted_address_o !== want.evicted || entry_count_o !== want.count) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t: beat %0d exp outcome %0d slot %0d evicted %h count %0d, got %0d %0d %h %0d",
                 $realtime, results_out, want.outcome, want.slot, want.evicted, want.count,
                 outcome_o, slot_o, evicted_address_o, entry_count_o);
    end
  endtask

  // Input side: walks the directed table, then random adds, then ends the run.
  initial begin : pairing_source
    pair_req_t req;
    pair_res_t res;
    bit        idle_ok;
    in_valid_i           <= 1'b0;
    device_address_i     <= '0;
    address_kind_i       <= '0;
    long_key_high_i      <= '0;
    long_key_low_i       <= '0;
    identity_key_high_i  <= '0;
    identity_key_low_i   <= '0;
    identity_key_given_i <= 1'b0;
    now_ms_i             <= '0;
    bond_used   = 0;
    items_in    = 0;
    results_out = 0;
    fault_count = 0;
    clock_ms    = 32'd5000;
    for (int k = 0; k < CACHE_ENTRIES; k++) bond_tab[k] = '{default: '0};
    build_table();
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);

    for (int i = 0; i < ITEM_TOTAL; i++) begin
      if (i < dir_table.size()) req = dir_table[i].req;
      else req = random_request();
      // Gaps come in bursts, with quiet stretches and none near the end.
      idle_ok = (i < ITEM_TOTAL - CALM_TAIL) && ((i / 100) % 3 != 2);
      if (idle_ok && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      device_address_i     <= req.addr;
      address_kind_i       <= req.kind;
      long_key_high_i      <= req.long_hi;
      long_key_low_i       <= req.long_lo;
      identity_key_high_i  <= req.ident_hi;
      identity_key_low_i   <= req.ident_lo;
      identity_key_given_i <= req.ident_given;
      now_ms_i             <= req.now;
      in_valid_i           <= 1'b1;
      @(posedge clk_i);
      while (in_stall_o !== 1'b0) @(posedge clk_i);
      // The beat was taken at this edge.
      res = predict_pairing(req);
      if (i < dir_table.size() && dir_table[i].fixed) res = dir_table[i].res;
      pending_results.push_back(res);
      items_in++;
    end
    in_valid_i <= 1'b0;

    // Drain, then allow for a late stray beat.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Long receiver hold-off so the block fills up and stalls its input.
  initial begin : receiver_hold
    hold_off <= 1'b0;
    while (items_in < HOLD_AT) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Output side: checks accepted beats and drives stall in short random bursts.
  initial begin : result_sink
    int stall_left;
    bit idle_ok;
    out_stall_i <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) check_result();
      idle_ok = (results_out < ITEM_TOTAL - CALM_TAIL) && ((results_out / 120) % 4 != 3);
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (idle_ok && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/bkc_pkg.sv
rtl/core/bkc_cell.sv
rtl/core/bonding_key_cache_lru_top.sv
sim/tb_top.sv
